>>> rtl/cbpa_pkg.sv
`timescale 1ns / 1ps

package cbpa_pkg;

  // Default geometry
  localparam int CHUNKS_DEF = 8;
  localparam int BLOCKS_DEF = 256;

  // Field and register widths
  localparam int CNT_W      = 9;
  localparam int BB_W       = 16;
  localparam int CHUNK_W    = 3;
  localparam int BLOCK_W    = 8;
  localparam int OFS_W      = 24;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Counter saturation value
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0] BPC_RST = CNT_W'(256);
  localparam logic [BB_W-1:0]  BB_RST  = BB_W'(16);

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCKS_PER_CHUNK = 2'd0,
    REG_BLOCK_BYTES      = 2'd1
  } cfg_reg_e;

endpackage

>>> rtl/cbpa_if.sv
`timescale 1ns / 1ps

// Request channel: one alloc or free word
interface cbpa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [cbpa_pkg::CHUNK_W-1:0] chunk_id;
  logic [cbpa_pkg::BLOCK_W-1:0] block_id;

  modport source (output valid, opcode, chunk_id, block_id, input ready);
  modport sink   (input valid, opcode, chunk_id, block_id, output ready);
endinterface

// Response channel: one result word per request
interface cbpa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cbpa_pkg::STATUS_W-1:0] status;
  logic [cbpa_pkg::CHUNK_W-1:0]  chunk_out;
  logic [cbpa_pkg::BLOCK_W-1:0]  block_out;
  logic [cbpa_pkg::OFS_W-1:0]    byte_offset;

  modport source (output valid, status, chunk_out, block_out, byte_offset, input ready);
  modport sink   (input valid, status, chunk_out, block_out, byte_offset, output ready);
endinterface

// Configuration write channel
interface cbpa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cbpa_pkg::CFG_IDX_W-1:0]  index;
  logic [cbpa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/chunked_block_pool_allocator_core.sv
// An accepted request passes the lookup state, where the link memory is read, and
// then the done state, where the head/count update uses that read data and the
// result is registered once the output is free, as the next request is taken.
// Reset (rst_ni, async, active low): per-chunk counters, heads and current chunk
// return to their initial values at once; the link memory is not cleared.
`timescale 1ns / 1ps

module chunked_block_pool_allocator_core #(
  parameter int CHUNKS = cbpa_pkg::CHUNKS_DEF,
  parameter int BLOCKS = cbpa_pkg::BLOCKS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cbpa_req_if.sink   in_i,
  cbpa_rsp_if.source out_o,
  cbpa_cfg_if.sink   cfg_i
);
  import cbpa_pkg::*;

  localparam int CIW   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int BIW   = $clog2(BLOCKS);
  localparam int DEPTH = CHUNKS * BLOCKS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = BIW + BB_W;
  localparam logic [CNT_W-1:0] RST_FREE = CNT_W'((BLOCKS < 256) ? BLOCKS : 256);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_DONE = 3'b100
  } state_e;

  // Reduce a stored link or head to a block index (values never exceed BLOCKS)
  function automatic logic [BIW-1:0] to_idx(logic [CNT_W-1:0] v);
    int w;
    w = (int'(v) == BLOCKS) ? 0 : int'(v);
    return BIW'(w);
  endfunction

  function automatic logic [AW-1:0] slot_addr(logic [CIW-1:0] c, logic [BIW-1:0] b);
    return AW'(int'(c) * BLOCKS + int'(b));
  endfunction

  state_e state_q, state_d;

  // Captured request
  logic               op_q;
  logic [CHUNK_W-1:0] cid_q;
  logic [BLOCK_W-1:0] bid_q;

  // Configuration
  logic [CNT_W-1:0] bpc_cfg_q;
  logic [BB_W-1:0]  bb_q;
  logic [CNT_W-1:0] bpc;

  // Per-chunk state
  logic [CNT_W-1:0] fc_q   [CHUNKS];
  logic [CNT_W-1:0] fc_d   [CHUNKS];
  logic [CNT_W-1:0] init_q [CHUNKS];
  logic [CNT_W-1:0] init_d [CHUNKS];
  logic [CNT_W-1:0] head_q [CHUNKS];
  logic [CNT_W-1:0] head_d [CHUNKS];
  logic [CIW-1:0]   cur_q, cur_d;

  // Lookup stage results
  logic [CIW-1:0]   chk_q, chk_d;
  logic [BIW-1:0]   blk_q, blk_d;
  status_e          st_q, st_d;
  logic             fwd_q, fwd_d;
  logic [CNT_W-1:0] fwd_val_q, fwd_val_d;

  // Link memory
  logic [CNT_W-1:0] link_mem [DEPTH];
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [CNT_W-1:0] wr_data, rdata_q;

  // Output register
  logic               ov_q;
  status_e            ost_q;
  logic [CHUNK_W-1:0] ochunk_q;
  logic [BLOCK_W-1:0] oblock_q;
  logic [OFS_W-1:0]   oofs_q;

  logic             hit;
  logic [CIW-1:0]   hit_c;
  logic [CIW-1:0]   free_c;
  logic [BIW-1:0]   head_idx, init_idx;
  logic [CNT_W-1:0] fc_inc;
  logic [PW-1:0]    prod;
  logic             out_free, leave_done, in_ready, in_fire, cfg_fire;

  // Clamp blocks per chunk to 1..BLOCKS
  always_comb begin
    if (bpc_cfg_q == '0) begin
      bpc = CNT_W'(1);
    end else if (int'(bpc_cfg_q) > BLOCKS) begin
      bpc = CNT_W'(BLOCKS);
    end else begin
      bpc = bpc_cfg_q;
    end
  end

  // Find the lowest chunk at or above current with free blocks
  always_comb begin
    hit   = 1'b0;
    hit_c = '0;
    for (int i = CHUNKS - 1; i >= 0; i--) begin
      if (i >= int'(cur_q) && fc_q[i] != '0) begin
        hit   = 1'b1;
        hit_c = CIW'(i);
      end
    end
  end

  // Handshakes
  assign out_free   = !ov_q || out_o.ready;
  assign leave_done = (state_q == S_DONE) && out_free;
  assign in_ready   = (state_q == S_IDLE) || leave_done;
  assign in_fire    = in_i.valid && in_ready;
  assign cfg_fire   = cfg_i.valid && cfg_i.ready;
  assign in_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;

  // Sequence lookup and update
  always_comb begin
    state_d   = state_q;
    fc_d      = fc_q;
    init_d    = init_q;
    head_d    = head_q;
    cur_d     = cur_q;
    chk_d     = chk_q;
    blk_d     = blk_q;
    st_d      = st_q;
    fwd_d     = fwd_q;
    fwd_val_d = fwd_val_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    free_c    = CIW'(cid_q);
    head_idx  = to_idx(head_q[hit_c]);
    init_idx  = to_idx(init_q[hit_c]);
    fc_inc    = (fc_q[free_c] == CNT_MAX) ? fc_q[free_c] : fc_q[free_c] + CNT_W'(1);

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_LOOK;
        end
      end

      S_LOOK: begin
        state_d = S_DONE;
        fwd_d   = 1'b0;
        chk_d   = '0;
        blk_d   = '0;
        if (op_q == OP_ALLOC) begin
          if (!hit) begin
            st_d = ST_FULL;
          end else begin
            // Take the head block, build the list one entry further if needed
            st_d    = ST_OK;
            chk_d   = hit_c;
            cur_d   = hit_c;
            blk_d   = head_idx;
            rd_en   = 1'b1;
            rd_addr = slot_addr(hit_c, head_idx);
            if (init_q[hit_c] < bpc) begin
              wr_en          = 1'b1;
              wr_addr        = slot_addr(hit_c, init_idx);
              wr_data        = init_q[hit_c] + CNT_W'(1);
              init_d[hit_c]  = init_q[hit_c] + CNT_W'(1);
              fwd_d          = (init_idx == head_idx);
              fwd_val_d      = init_q[hit_c] + CNT_W'(1);
            end
          end
        end else begin
          if (int'(cid_q) >= CHUNKS || CNT_W'(bid_q) >= bpc) begin
            st_d = ST_BAD;
          end else begin
            // Push the block and reset the chunk once it is wholly free
            st_d    = ST_OK;
            wr_en   = 1'b1;
            wr_addr = slot_addr(free_c, to_idx(CNT_W'(bid_q)));
            wr_data = (fc_q[free_c] != '0) ? head_q[free_c] : init_q[free_c];
            if (fc_inc >= bpc) begin
              fc_d[free_c]   = bpc;
              init_d[free_c] = '0;
              head_d[free_c] = '0;
            end else begin
              fc_d[free_c]   = fc_inc;
              head_d[free_c] = CNT_W'(bid_q);
            end
            if (free_c < cur_q) begin
              cur_d = free_c;
            end
          end
        end
      end

      S_DONE: begin
        if (leave_done) begin
          if (op_q == OP_ALLOC && st_q == ST_OK) begin
            fc_d[chk_q] = fc_q[chk_q] - CNT_W'(1);
            if (fc_q[chk_q] != CNT_W'(1)) begin
              head_d[chk_q] = fwd_q ? fwd_val_q : rdata_q;
            end else begin
              head_d[chk_q] = bpc;
            end
          end
          state_d = in_fire ? S_LOOK : S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_q   <= '0;
      ov_q    <= 1'b0;
      for (int i = 0; i < CHUNKS; i++) begin
        fc_q[i]   <= RST_FREE;
        init_q[i] <= '0;
        head_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      fc_q    <= fc_d;
      init_q  <= init_d;
      head_q  <= head_d;
      if (leave_done) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpc_cfg_q <= BPC_RST;
      bb_q      <= BB_RST;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        REG_BLOCKS_PER_CHUNK: bpc_cfg_q <= CNT_W'(cfg_i.data);
        REG_BLOCK_BYTES:      bb_q      <= BB_W'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // Request capture and lookup results
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= in_i.opcode;
      cid_q <= in_i.chunk_id;
      bid_q <= in_i.block_id;
    end
    chk_q     <= chk_d;
    blk_q     <= blk_d;
    st_q      <= st_d;
    fwd_q     <= fwd_d;
    fwd_val_q <= fwd_val_d;
  end

  // Link memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= link_mem[rd_addr];
    end
  end

  // Scale block index to a byte offset
  assign prod = blk_q * bb_q;

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (leave_done) begin
      ost_q <= st_q;
      if (op_q == OP_ALLOC && st_q == ST_OK) begin
        ochunk_q <= CHUNK_W'(chk_q);
        oblock_q <= BLOCK_W'(blk_q);
        oofs_q   <= OFS_W'(prod);
      end else begin
        ochunk_q <= '0;
        oblock_q <= '0;
        oofs_q   <= '0;
      end
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.status      = ost_q;
  assign out_o.chunk_out   = ochunk_q;
  assign out_o.block_out   = oblock_q;
  assign out_o.byte_offset = oofs_q;

endmodule
